/* hw/rtl/cfp_pkg.sv */
`timescale 1ns / 1ps
package cfp_pkg;

  // Status codes carried in a status beat
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ERRFRAME = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_TOOLARGE = 3'd4;

  // Result kinds (out_tuser)
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Frame bytes
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_TFI  = 8'hD5;
  localparam logic [7:0] BYTE_ERR  = 8'h7F;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  localparam logic [15:0] CAPACITY_RESET = 16'd255;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [15:0] count;
    logic [2:0]  status;
    logic [7:0]  pbyte;
  } item_t;

endpackage

/* hw/rtl/checksummed_frame_parser_core.sv */
`timescale 1ns / 1ps
// Channel  | Dir | tdata                       | tuser          | tlast
// ---------+-----+-----------------------------+----------------+--------------
// in_      | in  | [7:0] rx_byte               | first_of_read  | last_of_read
// out_     | out | [7:0] payload_byte,         | kind           | last
//          |     | [10:8] status,              | (0 data,       |
//          |     | [26:11] payload_count       |  1 status)     |
// cfg_     | in  | cfg_wr_data = payload_capacity, written when cfg_wr_en
//
// One input beat per clock while in_tready is high. Each beat is parsed in
// the cycle it is accepted and yields zero, one or two result beats, pushed
// into a 4-entry output queue; in_tready is high while the queue has room
// for two beats. Results appear on out_ in the cycle after the input beat
// at the earliest. Reset (rst_n low, synchronous) empties the queue, sets
// the parser idle until a first_of_read beat and loads payload_capacity
// with 255. A stalled out_ side fills the queue and then holds in_tready low.
module checksummed_frame_parser_core
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // first_of_read
  input  logic        in_tlast,   // last_of_read
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [10:8] status,
                                  // [26:11] payload_count, [31:27] zero
  output logic        out_tuser,  // kind
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // Parser phases
  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_LEN     = 4'd1;
  localparam logic [3:0] PH_NLCS    = 4'd2;
  localparam logic [3:0] PH_EXTH    = 4'd3;
  localparam logic [3:0] PH_EXTL    = 4'd4;
  localparam logic [3:0] PH_EXTLCS  = 4'd5;
  localparam logic [3:0] PH_TFI     = 4'd6;
  localparam logic [3:0] PH_TFI_ERR = 4'd7;
  localparam logic [3:0] PH_DATA    = 4'd8;
  localparam logic [3:0] PH_DCS     = 4'd9;

  logic [15:0] capacity_r;

  logic [3:0]  phase_r,      phase_nxt;
  logic        prev_zero_r,  prev_zero_nxt;
  logic [7:0]  len_hi_r,     len_hi_nxt;
  logic [15:0] info_len_r,   info_len_nxt;
  logic [15:0] seen_r,       seen_nxt;
  logic [7:0]  sum_r,        sum_nxt;
  logic        done_r,       done_nxt;

  item_t       emit [2];
  logic [1:0]  emit_cnt;

  item_t                mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r,    cnt_nxt;

  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic [7:0]  sum_b;
  logic [16:0] seen_inc;
  logic [15:0] pay_len;

  function automatic item_t status_item(input logic [2:0] st, input logic [15:0] c);
    item_t it;
    it.kind   = KIND_STATUS;
    it.last   = 1'b1;
    it.status = st;
    it.count  = (st == ST_OK) ? c : 16'd0;
    it.pbyte  = 8'd0;
    return it;
  endfunction

  function automatic item_t data_item(input logic [7:0] d);
    item_t it;
    it.kind   = KIND_DATA;
    it.last   = 1'b0;
    it.status = ST_OK;
    it.count  = 16'd0;
    it.pbyte  = d;
    return it;
  endfunction

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign b        = in_tdata;
  assign sum_b    = sum_r + b;
  assign pay_len  = info_len_r - 16'd1;

  // One parse step per accepted beat.
  always_comb begin
    phase_nxt     = phase_r;
    prev_zero_nxt = prev_zero_r;
    len_hi_nxt    = len_hi_r;
    info_len_nxt  = info_len_r;
    seen_nxt      = seen_r;
    sum_nxt       = sum_r;
    done_nxt      = done_r;
    emit[0]       = '0;
    emit[1]       = '0;
    emit_cnt      = 2'd0;
    seen_inc      = {1'b0, seen_r} + 17'd2;

    if (in_tuser) begin
      // status byte: close any open frame, restart
      if (!done_r) begin
        emit[emit_cnt[0]] = status_item(ST_INVALID, 16'd0);
        emit_cnt = emit_cnt + 2'd1;
      end
      phase_nxt     = PH_HUNT;
      prev_zero_nxt = 1'b0;
      len_hi_nxt    = 8'd0;
      info_len_nxt  = 16'd0;
      seen_nxt      = 16'd0;
      sum_nxt       = 8'd0;
      done_nxt      = 1'b0;
      if (in_tlast) begin
        emit[emit_cnt[0]] = status_item(ST_INVALID, 16'd0);
        emit_cnt = emit_cnt + 2'd1;
        done_nxt = 1'b1;
      end
    end else if (!done_r) begin
      case (phase_r)
        PH_HUNT: begin
          if (prev_zero_r && b == BYTE_FF) phase_nxt = PH_LEN;
          prev_zero_nxt = (b == BYTE_ZERO);
        end
        PH_LEN: begin
          len_hi_nxt = b;
          phase_nxt  = PH_NLCS;
        end
        PH_NLCS: begin
          if (len_hi_r == BYTE_FF && b == BYTE_FF) begin
            phase_nxt = PH_EXTH;
          end else if (len_hi_r + b != 8'd0) begin
            emit[emit_cnt[0]] = status_item(ST_CHECKSUM, 16'd0);
            emit_cnt = emit_cnt + 2'd1;
            done_nxt = 1'b1;
          end else if (len_hi_r == BYTE_ZERO) begin
            emit[emit_cnt[0]] = status_item(ST_INVALID, 16'd0);
            emit_cnt = emit_cnt + 2'd1;
            done_nxt = 1'b1;
          end else begin
            info_len_nxt = {8'd0, len_hi_r};
            // LEN 01 may be the application error frame
            phase_nxt = (len_hi_r == BYTE_ONE) ? PH_TFI_ERR : PH_TFI;
          end
        end
        PH_EXTH: begin
          len_hi_nxt = b;
          phase_nxt  = PH_EXTL;
        end
        PH_EXTL: begin
          info_len_nxt = {len_hi_r, b};
          sum_nxt      = len_hi_r + b;
          phase_nxt    = PH_EXTLCS;
        end
        PH_EXTLCS: begin
          if (sum_b != 8'd0) begin
            emit[emit_cnt[0]] = status_item(ST_CHECKSUM, 16'd0);
            emit_cnt = emit_cnt + 2'd1;
            done_nxt = 1'b1;
          end else if (info_len_r == 16'd0) begin
            emit[emit_cnt[0]] = status_item(ST_INVALID, 16'd0);
            emit_cnt = emit_cnt + 2'd1;
            done_nxt = 1'b1;
          end else begin
            phase_nxt = PH_TFI;
          end
        end
        PH_TFI, PH_TFI_ERR: begin
          if (phase_r == PH_TFI_ERR && b == BYTE_ERR) begin
            emit[emit_cnt[0]] = status_item(ST_ERRFRAME, 16'd0);
            emit_cnt = emit_cnt + 2'd1;
            done_nxt = 1'b1;
          end else if (b != BYTE_TFI) begin
            emit[emit_cnt[0]] = status_item(ST_INVALID, 16'd0);
            emit_cnt = emit_cnt + 2'd1;
            done_nxt = 1'b1;
          end else begin
            sum_nxt   = BYTE_TFI;
            seen_nxt  = 16'd0;
            phase_nxt = (info_len_r == 16'd1) ? PH_DCS : PH_DATA;
          end
        end
        PH_DATA: begin
          emit[emit_cnt[0]] = data_item(b);
          emit_cnt = emit_cnt + 2'd1;
          sum_nxt  = sum_b;
          seen_nxt = seen_r + 16'd1;
          // seen_inc is the new count plus one (TFI included)
          if (seen_inc >= {1'b0, info_len_r}) phase_nxt = PH_DCS;
        end
        PH_DCS: begin
          if (sum_b != 8'd0) begin
            emit[emit_cnt[0]] = status_item(ST_CHECKSUM, 16'd0);
          end else if (pay_len > capacity_r) begin
            emit[emit_cnt[0]] = status_item(ST_TOOLARGE, 16'd0);
          end else begin
            emit[emit_cnt[0]] = status_item(ST_OK, pay_len);
          end
          emit_cnt = emit_cnt + 2'd1;
          done_nxt = 1'b1;
        end
        default: begin
          emit[emit_cnt[0]] = status_item(ST_INVALID, 16'd0);
          emit_cnt = emit_cnt + 2'd1;
          done_nxt = 1'b1;
        end
      endcase
      // read ended with the frame still open: truncated
      if (!done_nxt && in_tlast) begin
        emit[emit_cnt[0]] = status_item(ST_INVALID, 16'd0);
        emit_cnt = emit_cnt + 2'd1;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      prev_zero_r <= 1'b0;
      len_hi_r    <= 8'd0;
      info_len_r  <= 16'd0;
      seen_r      <= 16'd0;
      sum_r       <= 8'd0;
      done_r      <= 1'b1;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      prev_zero_r <= prev_zero_nxt;
      len_hi_r    <= len_hi_nxt;
      info_len_r  <= info_len_nxt;
      seen_r      <= seen_nxt;
      sum_r       <= sum_nxt;
      done_r      <= done_nxt;
    end
  end

  // Output queue
  assign in_tready = (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) cnt_nxt = cnt_nxt + OUT_CNT_W'(emit_cnt);
    if (out_acc) cnt_nxt = cnt_nxt - OUT_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(emit_cnt);
      if (out_acc) rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit_cnt != 2'd0) mem_r[wr_ptr_r] <= emit[0];
    if (in_acc && emit_cnt == 2'd2) mem_r[wr_ptr_r + OUT_PTR_W'(1)] <= emit[1];
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {5'd0, mem_r[rd_ptr_r].count, mem_r[rd_ptr_r].status,
                       mem_r[rd_ptr_r].pbyte};
  assign out_tuser  = mem_r[rd_ptr_r].kind;
  assign out_tlast  = mem_r[rd_ptr_r].last;

endmodule

/* hw/rtl/cfp_checker.sv */
`timescale 1ns / 1ps
module cfp_checker
  import cfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // data beats never close a frame and carry no status
  a_data_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DATA |-> !out_tlast && out_tdata[26:8] == 19'd0)
    else $error("malformed data beat");

  // status beats close the frame, carry no byte, use a defined code
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATUS |->
      out_tlast && out_tdata[7:0] == 8'd0 && out_tdata[10:8] <= ST_TOOLARGE)
    else $error("malformed status beat");

  // only an ok status reports a payload count
  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATUS && out_tdata[10:8] != ST_OK |->
      out_tdata[26:11] == 16'd0)
    else $error("count on failed frame");

endmodule

bind checksummed_frame_parser_core cfp_checker u_cfp_checker (.*);

/* bench/tb_checksummed_frame_parser_core.sv */
`timescale 1ns / 1ps
module tb_checksummed_frame_parser_core;
  import cfp_pkg::*;

  // Cycles with no beat moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // Quiet cycles after the last expected beat; some input beats produce nothing
  localparam int SETTLE_CYCLES = 8;

  // Parser position inside one frame
  typedef enum logic [3:0] {
    P_HUNT, P_LEN, P_NLCS, P_EXTH, P_EXTL, P_EXTLCS, P_TFI, P_TFI_ERR, P_DATA, P_DCS
  } parse_phase_e;

  // What goes wrong in a generated read (F_GOOD: nothing)
  typedef enum int {
    F_GOOD, F_LCS, F_TFI, F_DCS, F_CUT, F_ABANDON, F_ERRFRAME, F_ZEROLEN, F_NOISE,
    F_TRAIL
  } frame_fault_e;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // first_of_read
  logic        in_tlast;   // last_of_read
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [7:0] payload_byte, [10:8] status, [26:11] payload_count
  logic        out_tuser;  // kind
  logic        out_tlast;  // last
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int src_idle_pct;
  int sink_stall_pct;
  int beats_sent;
  int fail_count;
  int idle_cycles;

  item_t      frame_results_q[$];  // result beats still owed by the parser
  logic [7:0] read_bytes_q[$];     // bytes of the read being sent

  // Shadow copy of the parser state
  parse_phase_e prs_phase;
  logic         prs_prev_zero;
  logic [8:0]   prs_len_hi;      // bit 8 set on the extended path
  logic [15:0]  prs_info_len;    // TFI + DATA
  logic [15:0]  prs_data_seen;
  logic [7:0]   prs_sum;
  logic         prs_closed;
  logic [15:0]  capacity;

  checksummed_frame_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame parser prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_frame_state();
    prs_phase     = P_HUNT;
    prs_prev_zero = 1'b0;
    prs_len_hi    = '0;
    prs_info_len  = '0;
    prs_data_seen = '0;
    prs_sum       = '0;
  endfunction

  // Closing status beat; count only survives on an ok frame
  function automatic void expect_status(logic [2:0] st, logic [15:0] cnt);
    item_t s;
    s        = '0;
    s.kind   = KIND_STATUS;
    s.last   = 1'b1;
    s.status = st;
    s.count  = (st == ST_OK) ? cnt : 16'd0;
    frame_results_q.push_back(s);
    prs_closed = 1'b1;
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b, logic first, logic lst);
    item_t d;
    // Status byte of a new read: close any open frame, restart, skip the byte
    if (first) begin
      if (!prs_closed) expect_status(ST_INVALID, '0);
      clear_frame_state();
      prs_closed = 1'b0;
      if (lst) expect_status(ST_INVALID, '0);
      return;
    end
    if (prs_closed) return;

    case (prs_phase)
      P_HUNT: begin
        if (prs_prev_zero && b == BYTE_FF) prs_phase = P_LEN;
        prs_prev_zero = (b == BYTE_ZERO);
      end
      P_LEN: begin
        prs_len_hi = {1'b0, b};
        prs_phase  = P_NLCS;
      end
      P_NLCS: begin
        // LEN FF LCS FF means extended; LEN FF with any other LCS is normal
        if (prs_len_hi == {1'b0, BYTE_FF} && b == BYTE_FF) begin
          prs_phase = P_EXTH;
        end else if (8'(prs_len_hi[7:0] + b) != 8'd0) begin
          expect_status(ST_CHECKSUM, '0);
        end else if (prs_len_hi == 9'd0) begin
          expect_status(ST_INVALID, '0);
        end else begin
          prs_info_len = {8'd0, prs_len_hi[7:0]};
          // LEN 01 / LCS FF may still turn out to be the error frame
          prs_phase = (prs_len_hi == {1'b0, BYTE_ONE}) ? P_TFI_ERR : P_TFI;
        end
      end
      P_EXTH: begin
        prs_len_hi = {1'b1, b};
        prs_phase  = P_EXTL;
      end
      P_EXTL: begin
        prs_info_len = {prs_len_hi[7:0], b};
        prs_sum      = 8'(prs_len_hi[7:0] + b);
        prs_phase    = P_EXTLCS;
      end
      P_EXTLCS: begin
        if (8'(prs_sum + b) != 8'd0) expect_status(ST_CHECKSUM, '0);
        else if (prs_info_len == 16'd0) expect_status(ST_INVALID, '0);
        else prs_phase = P_TFI;
      end
      P_TFI, P_TFI_ERR: begin
        if (prs_phase == P_TFI_ERR && b == BYTE_ERR) begin
          expect_status(ST_ERRFRAME, '0);
        end else if (b != BYTE_TFI) begin
          expect_status(ST_INVALID, '0);
        end else begin
          prs_sum       = BYTE_TFI;
          prs_data_seen = '0;
          prs_phase     = (prs_info_len == 16'd1) ? P_DCS : P_DATA;
        end
      end
      P_DATA: begin
        d        = '0;
        d.kind   = KIND_DATA;
        d.pbyte  = b;
        frame_results_q.push_back(d);
        prs_sum       = 8'(prs_sum + b);
        prs_data_seen = prs_data_seen + 16'd1;
        if (17'(prs_data_seen) + 17'd1 >= 17'(prs_info_len)) prs_phase = P_DCS;
      end
      P_DCS: begin
        // checksum beats size
        if (8'(prs_sum + b) != 8'd0) expect_status(ST_CHECKSUM, '0);
        else if (prs_info_len - 16'd1 > capacity) expect_status(ST_TOOLARGE, '0);
        else expect_status(ST_OK, prs_info_len - 16'd1);
      end
      default: expect_status(ST_INVALID, '0);
    endcase

    // Read ended before the frame got its status
    if (!prs_closed && lst) expect_status(ST_INVALID, '0);
  endfunction

  function automatic void check_result_beat();
    item_t want;
    if (frame_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result beat: tuser %0d tlast %0d tdata %08h",
                 out_tuser, out_tlast, out_tdata);
      return;
    end
    want = frame_results_q.pop_front();
    if (out_tuser !== want.kind || out_tlast !== want.last ||
        out_tdata[7:0] !== want.pbyte || out_tdata[10:8] !== want.status ||
        out_tdata[26:11] !== want.count) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: exp k%0d l%0d b%02h s%0d c%0d / got k%0d l%0d b%02h s%0d c%0d",
                 want.kind, want.last, want.pbyte, want.status, want.count,
                 out_tuser, out_tlast, out_tdata[7:0], out_tdata[10:8],
                 out_tdata[26:11]);
    end
  endfunction

  // Everything is sampled at the edge where it takes effect in the block
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame_state();
      prs_closed = 1'b1;
      capacity   = CAPACITY_RESET;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_tvalid && in_tready) parse_rx_byte(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) check_result_beat();
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Hang detection: no beat accepted on either side for too long
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic first, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // First byte carries first_of_read; tlast on the final byte when closing
  task automatic send_read(input bit close);
    for (int i = 0; i < read_bytes_q.size(); i++)
      send_beat(read_bytes_q[i], i == 0, close && (i == read_bytes_q.size() - 1));
  endtask

  // Stop sending and let the parser drain completely
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void build_read(int n_data, bit ext, frame_fault_e fault);
    logic [15:0] len;
    logic [7:0]  lcs;
    logic [7:0]  dsum;
    logic [7:0]  d;
    int          cut;
    read_bytes_q.delete();
    read_bytes_q.push_back(8'($urandom));  // transport status byte
    repeat ($urandom_range(2)) read_bytes_q.push_back(8'($urandom_range(254, 1)));
    if (fault == F_NOISE) begin
      repeat (n_data + 1) read_bytes_q.push_back(8'($urandom));
      return;
    end
    read_bytes_q.push_back(BYTE_ZERO);
    read_bytes_q.push_back(BYTE_FF);
    if (fault == F_ERRFRAME) begin
      read_bytes_q.push_back(BYTE_ONE);
      read_bytes_q.push_back(BYTE_FF);
      read_bytes_q.push_back(BYTE_ERR);
    end else begin
      len = (fault == F_ZEROLEN) ? 16'd0 : 16'(n_data + 1);
      if (ext) begin
        read_bytes_q.push_back(BYTE_FF);
        read_bytes_q.push_back(BYTE_FF);
        read_bytes_q.push_back(len[15:8]);
        read_bytes_q.push_back(len[7:0]);
        lcs = 8'(8'd0 - len[15:8] - len[7:0]);
      end else begin
        read_bytes_q.push_back(len[7:0]);
        lcs = 8'(8'd0 - len[7:0]);
      end
      if (fault == F_LCS) lcs = lcs ^ 8'($urandom_range(255, 1));
      read_bytes_q.push_back(lcs);
      if (fault != F_ZEROLEN) begin
        read_bytes_q.push_back((fault == F_TFI) ? (BYTE_TFI ^ 8'($urandom_range(255, 1)))
                                                : BYTE_TFI);
        dsum = BYTE_TFI;
        repeat (n_data) begin
          d = 8'($urandom);
          read_bytes_q.push_back(d);
          dsum = 8'(dsum + d);
        end
        dsum = 8'(8'd0 - dsum);
        if (fault == F_DCS) dsum = dsum ^ 8'($urandom_range(255, 1));
        read_bytes_q.push_back(dsum);
      end
    end
    if (fault == F_TRAIL)
      repeat ($urandom_range(3, 1)) read_bytes_q.push_back(8'($urandom));
    if (fault == F_CUT) begin
      cut = $urandom_range(read_bytes_q.size() - 2, 1);
      while (read_bytes_q.size() > cut + 1) void'(read_bytes_q.pop_back());
    end
  endfunction

  // Mostly well-formed frames of small size, a few near and past 255 bytes
  task automatic send_random_read();
    int           pick;
    int           n_data;
    bit           ext;
    frame_fault_e fault;
    pick = $urandom_range(99);
    if (pick < 80) n_data = $urandom_range(12, 0);
    else if (pick < 97) n_data = $urandom_range(60, 13);
    else n_data = $urandom_range(300, 240);
    ext  = ($urandom_range(3) == 0) || (n_data > 254);
    if ($urandom_range(99) < 55) fault = F_GOOD;
    else fault = frame_fault_e'($urandom_range(9, 1));
    build_read(n_data, ext, fault);
    send_read(fault != F_ABANDON);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_reads();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_beat(8'h5A, 1'b0, 1'b0);  // before any read: ignored
    read_bytes_q = '{BYTE_FF};     // read holding only the status byte
    send_read(1'b1);
    read_bytes_q = '{8'h00, 8'h12, BYTE_FF};  // no start code
    send_read(1'b1);
    // error frame, trailing byte ignored
    read_bytes_q = '{8'h01, BYTE_ZERO, BYTE_FF, BYTE_ONE, BYTE_FF, BYTE_ERR, 8'h99};
    send_read(1'b1);
    read_bytes_q = '{8'h02, BYTE_ZERO, BYTE_FF, 8'h00, 8'h00};  // zero length
    send_read(1'b1);
    read_bytes_q = '{8'h03, BYTE_ZERO, BYTE_FF, 8'h03, 8'h00};  // bad LCS
    send_read(1'b1);
    read_bytes_q = '{8'h04, BYTE_ZERO, BYTE_FF, 8'h02, 8'hFE, 8'h12};  // wrong TFI
    send_read(1'b1);
    // two data bytes 00 and FF
    read_bytes_q = '{8'h05, BYTE_ZERO, BYTE_FF, 8'h03, 8'hFD, BYTE_TFI, 8'h00, 8'hFF,
                     8'h2C};
    send_read(1'b1);
    // LEN 01 / LCS FF followed by TFI: empty ok frame
    read_bytes_q = '{8'h06, BYTE_ZERO, BYTE_FF, BYTE_ONE, BYTE_FF, BYTE_TFI, 8'h2B};
    send_read(1'b1);
    // extended header, one data byte
    read_bytes_q = '{8'h07, BYTE_ZERO, BYTE_FF, BYTE_FF, BYTE_FF, 8'h00, 8'h02, 8'hFE,
                     BYTE_TFI, 8'h80, 8'hAB};
    send_read(1'b1);
    // extended zero length
    read_bytes_q = '{8'h08, BYTE_ZERO, BYTE_FF, BYTE_FF, BYTE_FF, 8'h00, 8'h00, 8'h00};
    send_read(1'b1);
    read_bytes_q = '{8'h09, BYTE_ZERO, BYTE_FF, 8'h02, 8'hFE, BYTE_TFI, 8'h11, 8'h00};
    send_read(1'b1);  // bad DCS
    // LEN FF read as normal, cut short right after a data byte
    read_bytes_q = '{8'h0A, BYTE_ZERO, BYTE_FF, BYTE_FF, 8'h01, BYTE_TFI, 8'hFF};
    send_read(1'b1);
    // frame left open, then a new read starts
    read_bytes_q = '{8'h0B, BYTE_ZERO, BYTE_FF, 8'h02, 8'hFE, BYTE_TFI};
    send_read(1'b0);
    read_bytes_q = '{8'h00};
    send_read(1'b1);
  endtask

  task automatic test_capacity_limits();
    write_capacity(16'd0);
    read_bytes_q = '{8'h10, BYTE_ZERO, BYTE_FF, 8'h02, 8'hFE, BYTE_TFI, 8'h01, 8'h2A};
    send_read(1'b1);  // too large
    read_bytes_q[7] = 8'h2B;
    send_read(1'b1);  // bad DCS wins over size
    write_capacity(16'd1);
    read_bytes_q[7] = 8'h2A;
    send_read(1'b1);  // fits exactly
    write_capacity(16'hFFFF);
    send_read(1'b1);
  endtask

  task automatic test_random_reads(input int src_pct, input int sink_pct,
                                   input int n_beats);
    int stop_at;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    stop_at        = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      // occasional stray byte between reads
      if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'($urandom));
      send_random_read();
    end
  endtask

  // Sender holds off until the parser has returned everything, then resumes
  task automatic test_drain_pause();
    src_idle_pct   = 0;
    sink_stall_pct = 58;
    repeat (4) send_random_read();
    wait_drained();
    repeat (4) send_random_read();
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    beats_sent  = 0;
    fail_count  = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_reads();
    test_capacity_limits();
    test_random_reads(0, 0, 300);
    write_capacity(16'($urandom_range(12, 0)));
    test_random_reads(58, 0, 300);
    test_drain_pause();
    write_capacity(16'($urandom_range(300, 13)));
    test_random_reads(0, 58, 300);
    write_capacity(CAPACITY_RESET);
    test_random_reads(33, 33, 300);
    wait_drained();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cfp_pkg.sv
hw/rtl/checksummed_frame_parser_core.sv
hw/rtl/cfp_checker.sv
bench/tb_checksummed_frame_parser_core.sv
